FILE: rtl/atpl_pkg.sv
// ----------------------------------------------------------------------------
// atpl_pkg - shared constants for the ADC to temperature converter
// Field widths, operation codes and the result range.
// ----------------------------------------------------------------------------
`default_nettype none

package atpl_pkg;

  localparam int MAX_PAIRS_DEF = 16;

  localparam int OP_W   = 1;
  localparam int IDX_W  = 4;
  localparam int TEMP_W = 21;
  localparam int ADC_W  = 16;
  localparam int CFG_W  = 5;

  // operation codes
  localparam logic [OP_W-1:0] OP_LOAD    = 1'b0;
  localparam logic [OP_W-1:0] OP_CONVERT = 1'b1;

  // result range (21-bit two's complement)
  localparam int TEMP_MIN = -(1 <<< (TEMP_W - 1));
  localparam int TEMP_MAX = (1 <<< (TEMP_W - 1)) - 1;

endpackage : atpl_pkg

`default_nettype wire

FILE: rtl/adc_to_temp_piecewise_linear.sv
// ----------------------------------------------------------------------------
// adc_to_temp_piecewise_linear - ADC sample to temperature by table lookup
// Piecewise linear interpolation over a loaded table of (temperature, adc)
// pairs, using a bit-serial divider and multiplier.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one word per item. A load
//   word (opcode 0) writes one table pair and gives no result. A convert
//   word (opcode 1) gives exactly one temperature word on the output channel
//   (out_valid_o / out_stall_i).
//   cfg_we_i/cfg_wdata_i set pairs_in_use; write it only while idle.
// Steps of a convert, accept to result register:
//   pairs_in_use = 0 : sample passed through
//   otherwise        : a read and a check state per table pair inspected in
//                      the search, plus, when interpolating, set-up, 21-step
//                      quotient, 16-step multiply, 16-step remainder divide,
//                      sum and saturate.
// The table memory has one read port with registered data, which is why each
// pair inspected takes a read state and a check state.
// One convert is in flight at a time; in_stall_o is high while it runs. The
// result sits in an output register, so a load may be taken while a result
// waits. A held output stalls a finished convert until the word is taken.
// Reset clears the control state and pairs_in_use; table contents are
// undefined until loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module adc_to_temp_piecewise_linear #(
  parameter int MAX_PAIRS = atpl_pkg::MAX_PAIRS_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // configuration
  input  wire logic                               cfg_we_i,
  input  wire logic [atpl_pkg::CFG_W-1:0]         cfg_wdata_i,
  // input channel
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic [atpl_pkg::OP_W-1:0]          opcode_i,
  input  wire logic [atpl_pkg::IDX_W-1:0]         entry_index_i,
  input  wire logic signed [atpl_pkg::TEMP_W-1:0] entry_temperature_i,
  input  wire logic [atpl_pkg::ADC_W-1:0]         entry_adc_i,
  input  wire logic [atpl_pkg::ADC_W-1:0]         sample_i,
  // output channel
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic signed [atpl_pkg::TEMP_W-1:0]      temperature_o
);

  localparam int TW   = atpl_pkg::TEMP_W;
  localparam int AW_D = atpl_pkg::ADC_W;
  localparam int PW   = TW + AW_D;                 // one table pair
  localparam int AW   = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
  localparam int KW   = $clog2(MAX_PAIRS + 1);     // holds the pair count
  localparam int XW   = TW + 1;                    // temperature difference
  localparam int DVW  = 2 * AW_D;                  // divider shift register
  localparam int QW   = TW + AW_D;                 // quotient times sample offset
  localparam int SW   = QW + 3;                    // final signed sum
  localparam int CW   = $clog2(TW);                // step counter

  localparam logic signed [SW-1:0] TMin = SW'(atpl_pkg::TEMP_MIN);
  localparam logic signed [SW-1:0] TMax = SW'(atpl_pkg::TEMP_MAX);

  // FSM codes
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_READ  = 4'd1;
  localparam logic [3:0] S_CHECK = 4'd2;
  localparam logic [3:0] S_PREP  = 4'd3;
  localparam logic [3:0] S_DIV1  = 4'd4;
  localparam logic [3:0] S_MUL   = 4'd5;
  localparam logic [3:0] S_DIV2  = 4'd6;
  localparam logic [3:0] S_SUM   = 4'd7;
  localparam logic [3:0] S_SAT   = 4'd8;
  localparam logic [3:0] S_PUSH  = 4'd9;

  // control
  logic [3:0]                  state_q, state_d;
  logic [atpl_pkg::CFG_W-1:0]  pairs_q;
  logic                        out_valid_q;
  logic [KW-1:0]               k_q;

  // table memory
  logic [PW-1:0]               mem_q [MAX_PAIRS];
  logic [PW-1:0]               rd_q;

  // datapath
  logic [AW_D-1:0]             val_q;
  logic signed [TW-1:0]        prev_t_q;
  logic [AW_D-1:0]             prev_a_q;
  logic signed [XW-1:0]        x_q;
  logic                        sx_q;
  logic [AW_D-1:0]             d_q;
  logic [AW_D-1:0]             nmag_q;
  logic [AW_D-1:0]             rem_q;
  logic [DVW-1:0]              quo_q;
  logic [CW-1:0]               cnt_q;
  logic [QW-1:0]               acc_q;
  logic [DVW-1:0]              prod_q;
  logic signed [TW-1:0]        res_q;
  logic signed [TW-1:0]        out_temp_q;

  logic                        accept;
  logic                        push_ok;
  logic [KW-1:0]               n_eff;
  logic [KW-1:0]               k_inc;
  logic signed [TW-1:0]        rd_t;
  logic [AW_D-1:0]             rd_a;
  logic                        hit;
  logic                        last;
  logic [AW_D:0]               rem_sh;
  logic                        ge;
  logic [AW_D-1:0]             rem_nx;
  logic [DVW-1:0]              quo_nx;
  logic [QW-1:0]               acc_nx;
  logic [DVW-1:0]              prod_nx;
  logic [XW-1:0]               xmag;
  logic signed [SW-1:0]        hi_w;
  logic signed [SW-1:0]        mag_w;
  logic signed [SW-1:0]        t_w;
  logic signed [TW-1:0]        sat;
  logic                        load_ok;

  assign accept  = in_valid_i && (state_q == S_IDLE);
  assign push_ok = !out_valid_q || !out_stall_i;
  assign load_ok = accept && (opcode_i == atpl_pkg::OP_LOAD)
                   && (32'(entry_index_i) < MAX_PAIRS);

  // pair count clipped to the table depth
  always_comb begin
    if (32'(pairs_q) > MAX_PAIRS) begin
      n_eff = KW'(MAX_PAIRS);
    end else begin
      n_eff = KW'(pairs_q);
    end
  end

  assign k_inc = k_q + 1'b1;
  assign rd_t  = rd_q[PW-1:AW_D];
  assign rd_a  = rd_q[AW_D-1:0];
  assign hit   = val_q >= rd_a;
  assign last  = (k_inc == n_eff);

  // restoring divider step, shared by both divides
  assign rem_sh = {rem_q, quo_q[DVW-1]};
  assign ge     = rem_sh >= {1'b0, d_q};
  assign rem_nx = ge ? AW_D'(rem_sh - {1'b0, d_q}) : rem_sh[AW_D-1:0];
  assign quo_nx = {quo_q[DVW-2:0], ge};

  // shift-add multiply step, sample offset bits taken msb first
  assign acc_nx  = {acc_q[QW-2:0], 1'b0}
                   + (nmag_q[AW_D-1] ? QW'(quo_q[TW-1:0]) : QW'(0));
  assign prod_nx = {prod_q[DVW-2:0], 1'b0}
                   + (nmag_q[AW_D-1] ? DVW'(rem_q) : DVW'(0));

  // magnitude of the temperature difference
  assign xmag = x_q[XW-1] ? XW'(-x_q) : XW'(x_q);

  // final sum with saturation
  assign hi_w  = SW'(prev_t_q);
  assign mag_w = SW'({3'b000, acc_q});
  assign t_w   = sx_q ? (hi_w - mag_w) : (hi_w + mag_w);
  always_comb begin
    if (t_w < TMin) begin
      sat = TW'(TMin);
    end else if (t_w > TMax) begin
      sat = TW'(TMax);
    end else begin
      sat = t_w[TW-1:0];
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept && (opcode_i == atpl_pkg::OP_CONVERT)) begin
          state_d = (n_eff == '0) ? S_PUSH : S_READ;
        end
      end
      S_READ:  state_d = S_CHECK;
      S_CHECK: begin
        if (hit) begin
          state_d = (k_q == '0) ? S_PUSH : S_PREP;
        end else begin
          state_d = last ? S_PUSH : S_READ;
        end
      end
      S_PREP:  state_d = S_DIV1;
      S_DIV1:  if (cnt_q == '0) state_d = S_MUL;
      S_MUL:   if (cnt_q == '0) state_d = S_DIV2;
      S_DIV2:  if (cnt_q == '0) state_d = S_SUM;
      S_SUM:   state_d = S_SAT;
      S_SAT:   state_d = S_PUSH;
      S_PUSH:  if (push_ok) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pairs_q     <= '0;
      out_valid_q <= 1'b0;
      k_q         <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        pairs_q <= cfg_wdata_i;
      end
      if ((state_q == S_PUSH) && push_ok) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == S_IDLE) begin
        k_q <= '0;
      end else if ((state_q == S_CHECK) && !hit) begin
        k_q <= k_inc;
      end
    end
  end

  // table store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (load_ok) begin
      mem_q[AW'(entry_index_i)] <= {entry_temperature_i, entry_adc_i};
    end
    rd_q <= mem_q[k_q[AW-1:0]];
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        val_q <= sample_i;
        res_q <= TW'({5'b00000, sample_i});
      end
      S_CHECK: begin
        if (hit) begin
          res_q  <= rd_t;                         // first pair matched
          x_q    <= XW'(rd_t) - XW'(prev_t_q);
          d_q    <= prev_a_q - rd_a;
          nmag_q <= prev_a_q - val_q;
        end else begin
          res_q    <= rd_t;                       // last pair if none left
          prev_t_q <= rd_t;
          prev_a_q <= rd_a;
        end
      end
      S_PREP: begin
        sx_q  <= x_q[XW-1];
        rem_q <= '0;
        quo_q <= {xmag[TW-1:0], (DVW-TW)'(0)};
        cnt_q <= CW'(TW - 1);
      end
      S_DIV1: begin
        rem_q <= rem_nx;
        quo_q <= quo_nx;
        if (cnt_q == '0) begin
          acc_q  <= '0;
          prod_q <= '0;
          cnt_q  <= CW'(AW_D - 1);
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
      S_MUL: begin
        acc_q  <= acc_nx;
        prod_q <= prod_nx;
        nmag_q <= {nmag_q[AW_D-2:0], 1'b0};
        if (cnt_q == '0) begin
          // high half of remainder product is below the span already
          rem_q <= prod_nx[DVW-1:AW_D];
          quo_q <= {prod_nx[AW_D-1:0], AW_D'(0)};
          cnt_q <= CW'(AW_D - 1);
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
      S_DIV2: begin
        rem_q <= rem_nx;
        quo_q <= quo_nx;
        cnt_q <= cnt_q - 1'b1;
      end
      S_SUM: begin
        acc_q <= acc_q + QW'(quo_q[AW_D-1:0]);
      end
      S_SAT: begin
        res_q <= sat;
      end
      S_PUSH: begin
        if (push_ok) begin
          out_temp_q <= res_q;
        end
      end
      default: begin
        cnt_q <= cnt_q;
      end
    endcase
  end

  assign in_stall_o    = (state_q != S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign temperature_o = out_temp_q;

endmodule : adc_to_temp_piecewise_linear

`default_nettype wire
